// ----- rtl/bsr_pkg.sv -----
package bsr_pkg;

	localparam int MAX_PROCESSES = 8;
	localparam int MAX_RESOURCES = 8;
	localparam int COUNT_BITS    = 8;
	localparam int SEQ_LIMIT     = 8;
	localparam int WORK_BITS     = 16;

	localparam int TABLE_DEPTH = MAX_PROCESSES * MAX_RESOURCES;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int RES_W       = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
	localparam int SEQ_W       = 3;
	localparam int CNT_W       = 4;

	localparam int PROC_LIMIT = (MAX_PROCESSES < SEQ_LIMIT) ? MAX_PROCESSES : SEQ_LIMIT;
	localparam int RES_LIMIT  = (MAX_RESOURCES < SEQ_LIMIT) ? MAX_RESOURCES : SEQ_LIMIT;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [WORK_BITS-1:0]  work_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	localparam logic [2:0] OP_WRITE_ALLOC = 3'd0;
	localparam logic [2:0] OP_WRITE_MAX   = 3'd1;
	localparam logic [2:0] OP_WRITE_AVAIL = 3'd2;
	localparam logic [2:0] OP_STAGE       = 3'd3;
	localparam logic [2:0] OP_SUBMIT      = 3'd4;
	localparam logic [2:0] OP_CHECK       = 3'd5;

	localparam logic [2:0] ST_ACK          = 3'd0;
	localparam logic [2:0] ST_EXCEEDS_NEED = 3'd1;
	localparam logic [2:0] ST_NOT_AVAIL    = 3'd2;
	localparam logic [2:0] ST_DENIED       = 3'd3;
	localparam logic [2:0] ST_GRANTED      = 3'd4;
	localparam logic [2:0] ST_SAFE         = 3'd5;
	localparam logic [2:0] ST_UNSAFE       = 3'd6;

	localparam logic [1:0] CFG_PROCESS_COUNT  = 2'd0;
	localparam logic [1:0] CFG_RESOURCE_COUNT = 2'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK_RD,
		S_CHK_EV,
		S_APP_RD,
		S_APP_WR,
		S_SAFE_INIT,
		S_PSEL,
		S_FIT_RD,
		S_FIT_EV,
		S_RB_RD,
		S_RB_WR,
		S_SINGLE,
		S_EMIT
	} state_t;

	function automatic cnt_t eff_count(input logic [3:0] raw, input cnt_t lim);
		cnt_t n;
		n = CNT_W'(raw);
		if (raw == 4'd0) n = CNT_W'(1);
		else if (CNT_W'(raw) > lim) n = lim;
		return n;
	endfunction

	function automatic logic [ADDR_W-1:0] tbl_addr(input cnt_t p, input cnt_t r);
		return ADDR_W'(32'(p) * MAX_RESOURCES + 32'(r));
	endfunction

endpackage

// ----- rtl/bsr_ram.sv -----
module bsr_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/bankers_safety_and_request_unit.sv -----
// a table write or stage gives its ack in the cycle after the transfer
// submit and check run a read-evaluate sequencer over the allocation and maximum memories,
// each element read taking a read state and then an evaluate state
// a safe sequence leaves one result per cycle while the output is not stalled; one item is worked on at a time
// reset clears the configuration to 8/8 and marks every table entry as zero through valid bits
module bankers_safety_and_request_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [2:0] process_index,
	input  logic [2:0] resource_index,
	input  logic [7:0] value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [2:0] sequence_process,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);
	import bsr_pkg::*;

	state_t state_q, state_d;

	logic [3:0] proc_cfg_q, res_cfg_q;
	logic [2:0] op_q;
	cnt_t       np_q, nr_q, p_sub_q, p_q, r_q, cnt_q, k_q;
	logic       exceed_q, short_q;
	logic [2:0] res_status_q, emit_status_q;

	count_t     avail_q [MAX_RESOURCES];
	count_t     stg_q   [MAX_RESOURCES];
	work_t      work_q  [MAX_RESOURCES];
	work_t      tmp_q   [MAX_RESOURCES];
	logic       finished_q [SEQ_LIMIT];
	logic [SEQ_W-1:0] seqbuf_q [SEQ_LIMIT];

	logic [TABLE_DEPTH-1:0] alloc_vld_q, max_vld_q;
	logic       alloc_vld_s1, max_vld_s1;

	logic       out_valid_q, last_q;
	logic [2:0] status_q, seqp_q;

	logic              in_fire, out_free;
	logic              rd_en, a_we, m_we;
	logic [ADDR_W-1:0] rd_addr, a_waddr, m_waddr;
	count_t            a_wdata, m_wdata, alloc_ram, max_ram, alloc_rd, max_rd;
	logic              out_load, out_last_d;
	logic [2:0]        out_status_d, out_seq_d;
	cnt_t              np_now, nr_now, row_p;
	logic [RES_W-1:0]  ri;
	logic [COUNT_BITS:0] need_d;
	logic              need_neg, exceed_r, short_r, fits_r, r_last, cnt_last;
	logic [WORK_BITS:0] sum;
	work_t             sum_sat;
	count_t            in_val;
	logic              tbl_ok, res_ok;

	bsr_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(COUNT_BITS)) u_alloc_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.re(rd_en), .raddr(rd_addr), .rdata(alloc_ram)
	);

	bsr_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(COUNT_BITS)) u_max_ram (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.re(rd_en), .raddr(rd_addr), .rdata(max_ram)
	);

	assign cfg_ready        = 1'b1;
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign sequence_process = seqp_q;
	assign last             = last_q;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == S_IDLE) && out_free);
	assign in_fire  = in_valid && !in_stall;

	assign np_now = eff_count(proc_cfg_q, CNT_W'(PROC_LIMIT));
	assign nr_now = eff_count(res_cfg_q, CNT_W'(RES_LIMIT));
	assign in_val = COUNT_BITS'(value);
	assign tbl_ok = (32'(process_index) < MAX_PROCESSES) && (32'(resource_index) < MAX_RESOURCES);
	assign res_ok = 32'(resource_index) < MAX_RESOURCES;

	assign alloc_rd = alloc_vld_s1 ? alloc_ram : '0;
	assign max_rd   = max_vld_s1 ? max_ram : '0;
	assign ri       = RES_W'(r_q);
	assign need_d   = {1'b0, max_rd} - {1'b0, alloc_rd};
	assign need_neg = need_d[COUNT_BITS];
	assign exceed_r = need_neg || (stg_q[ri] > need_d[COUNT_BITS-1:0]);
	assign short_r  = stg_q[ri] > avail_q[ri];
	assign fits_r   = need_neg || (WORK_BITS'(need_d[COUNT_BITS-1:0]) <= work_q[ri]);
	assign sum      = (WORK_BITS+1)'(work_q[ri]) + (WORK_BITS+1)'(alloc_rd);
	assign sum_sat  = sum[WORK_BITS] ? '1 : sum[WORK_BITS-1:0];
	assign r_last   = (r_q + CNT_W'(1)) == nr_q;
	assign cnt_last = (cnt_q + CNT_W'(1)) == np_q;
	assign row_p    = (state_q == S_FIT_RD) ? p_q : p_sub_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (operation == OP_SUBMIT) begin
						if (CNT_W'(process_index) >= np_now) state_d = S_SINGLE;
						else state_d = S_CHK_RD;
					end else if (operation == OP_CHECK) begin
						state_d = S_SAFE_INIT;
					end
				end
			end
			S_CHK_RD: state_d = S_CHK_EV;
			S_CHK_EV: begin
				if (r_last) begin
					if (exceed_q || exceed_r || short_q || short_r) state_d = S_SINGLE;
					else state_d = S_APP_RD;
				end else begin
					state_d = S_CHK_RD;
				end
			end
			S_APP_RD: state_d = S_APP_WR;
			S_APP_WR: state_d = r_last ? S_SAFE_INIT : S_APP_RD;
			S_SAFE_INIT: state_d = S_PSEL;
			S_PSEL: begin
				if (p_q >= np_q) state_d = (op_q == OP_SUBMIT) ? S_RB_RD : S_SINGLE;
				else if (!finished_q[p_q[SEQ_W-1:0]]) state_d = S_FIT_RD;
			end
			S_FIT_RD: state_d = S_FIT_EV;
			S_FIT_EV: begin
				if (!fits_r) state_d = S_PSEL;
				else if (r_last) state_d = cnt_last ? S_EMIT : S_PSEL;
				else state_d = S_FIT_RD;
			end
			S_RB_RD: state_d = S_RB_WR;
			S_RB_WR: state_d = r_last ? S_SINGLE : S_RB_RD;
			S_SINGLE: if (out_free) state_d = S_IDLE;
			S_EMIT: if (out_free && ((k_q + CNT_W'(1)) == np_q)) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory and result controls
	always_comb begin
		rd_en        = 1'b0;
		rd_addr      = tbl_addr(row_p, r_q);
		a_we         = 1'b0;
		a_waddr      = tbl_addr(p_sub_q, r_q);
		a_wdata      = alloc_rd + stg_q[ri];
		m_we         = 1'b0;
		m_waddr      = tbl_addr(CNT_W'(process_index), CNT_W'(resource_index));
		m_wdata      = in_val;
		out_load     = 1'b0;
		out_status_d = ST_ACK;
		out_seq_d    = '0;
		out_last_d   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (in_fire && tbl_ok) begin
					if (operation == OP_WRITE_ALLOC) begin
						a_we    = 1'b1;
						a_waddr = m_waddr;
						a_wdata = in_val;
					end
					if (operation == OP_WRITE_MAX) m_we = 1'b1;
				end
				if (in_fire && (operation inside {OP_WRITE_ALLOC, OP_WRITE_MAX,
						OP_WRITE_AVAIL, OP_STAGE})) begin
					out_load = 1'b1;
				end
			end
			S_CHK_RD, S_APP_RD, S_FIT_RD, S_RB_RD: rd_en = 1'b1;
			S_APP_WR: a_we = 1'b1;
			S_RB_WR: begin
				a_we    = 1'b1;
				a_wdata = alloc_rd - stg_q[ri];
			end
			S_SINGLE: begin
				out_load     = out_free;
				out_status_d = res_status_q;
			end
			S_EMIT: begin
				out_load     = out_free;
				out_status_d = emit_status_q;
				out_seq_d    = seqbuf_q[k_q[SEQ_W-1:0]];
				out_last_d   = (k_q + CNT_W'(1)) == np_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			proc_cfg_q   <= 4'd8;
			res_cfg_q    <= 4'd8;
			out_valid_q  <= 1'b0;
			alloc_vld_q  <= '0;
			max_vld_q    <= '0;
			alloc_vld_s1 <= 1'b0;
			max_vld_s1   <= 1'b0;
			for (int i = 0; i < MAX_RESOURCES; i++) begin
				avail_q[i] <= '0;
				stg_q[i]   <= '0;
				work_q[i]  <= '0;
			end
			for (int i = 0; i < SEQ_LIMIT; i++) finished_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_PROCESS_COUNT) proc_cfg_q <= cfg_data;
				if (cfg_index == CFG_RESOURCE_COUNT) res_cfg_q <= cfg_data;
			end
			if (a_we) alloc_vld_q[a_waddr] <= 1'b1;
			if (m_we) max_vld_q[m_waddr] <= 1'b1;
			if (rd_en) begin
				alloc_vld_s1 <= alloc_vld_q[rd_addr];
				max_vld_s1   <= max_vld_q[rd_addr];
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (operation == OP_WRITE_AVAIL && res_ok)
							avail_q[RES_W'(resource_index)] <= in_val;
						if (operation == OP_STAGE && res_ok)
							stg_q[RES_W'(resource_index)] <= in_val;
					end
				end
				S_APP_WR: avail_q[ri] <= avail_q[ri] - stg_q[ri];
				S_RB_WR: avail_q[ri] <= avail_q[ri] + stg_q[ri];
				S_SAFE_INIT: begin
					for (int i = 0; i < MAX_RESOURCES; i++)
						if (32'(i) < 32'(nr_q)) work_q[i] <= WORK_BITS'(avail_q[i]);
					for (int i = 0; i < SEQ_LIMIT; i++) finished_q[i] <= 1'b0;
				end
				S_FIT_EV: begin
					if (fits_r && r_last) begin
						for (int i = 0; i < MAX_RESOURCES; i++)
							work_q[i] <= (32'(i) == 32'(r_q)) ? sum_sat : tmp_q[i];
						finished_q[p_q[SEQ_W-1:0]] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// sequencer counters and payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= out_status_d;
			seqp_q   <= out_seq_d;
			last_q   <= out_last_d;
		end
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					op_q     <= operation;
					np_q     <= np_now;
					nr_q     <= nr_now;
					p_sub_q  <= CNT_W'(process_index);
					r_q      <= '0;
					exceed_q <= 1'b0;
					short_q  <= 1'b0;
					res_status_q  <= (operation == OP_CHECK) ? ST_UNSAFE : ST_EXCEEDS_NEED;
					emit_status_q <= (operation == OP_CHECK) ? ST_SAFE : ST_GRANTED;
				end
			end
			S_CHK_EV: begin
				exceed_q <= exceed_q | exceed_r;
				short_q  <= short_q | short_r;
				if (r_last) begin
					r_q <= '0;
					if (exceed_q || exceed_r) res_status_q <= ST_EXCEEDS_NEED;
					else res_status_q <= ST_NOT_AVAIL;
				end else begin
					r_q <= r_q + CNT_W'(1);
				end
			end
			S_APP_WR, S_RB_WR: r_q <= r_last ? '0 : r_q + CNT_W'(1);
			S_SAFE_INIT: begin
				p_q   <= '0;
				cnt_q <= '0;
				r_q   <= '0;
				k_q   <= '0;
			end
			S_PSEL: begin
				r_q <= '0;
				if (p_q < np_q && finished_q[p_q[SEQ_W-1:0]]) p_q <= p_q + CNT_W'(1);
				if (p_q >= np_q) res_status_q <= ST_DENIED;
				if (p_q >= np_q && op_q == OP_CHECK) res_status_q <= ST_UNSAFE;
			end
			S_FIT_EV: begin
				tmp_q[ri] <= sum_sat;
				if (!fits_r) begin
					p_q <= p_q + CNT_W'(1);
				end else if (r_last) begin
					seqbuf_q[cnt_q[SEQ_W-1:0]] <= p_q[SEQ_W-1:0];
					cnt_q <= cnt_q + CNT_W'(1);
					p_q   <= '0;
				end else begin
					r_q <= r_q + CNT_W'(1);
				end
			end
			S_EMIT: if (out_free) k_q <= k_q + CNT_W'(1);
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> state_q == S_IDLE)
		else $error("input taken while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIT_EV |-> cnt_q < np_q && p_q < np_q && r_q < nr_q)
		else $error("safety search index out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result overwritten before transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> k_q < np_q)
		else $error("sequence emission overrun");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import bsr_pkg::*;

	typedef struct packed {
		logic [2:0] st;
		logic [2:0] seq;
		logic       lst;
	} grant_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] operation;
	logic [2:0] process_index;
	logic [2:0] resource_index;
	logic [7:0] value;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] status;
	logic [2:0] sequence_process;
	logic       last;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [3:0] cfg_data;

	bankers_safety_and_request_unit dut (.*);

	// shadow copy of the block state
	logic [7:0]  alloc_m [8][8];
	logic [7:0]  max_m [8][8];
	logic [7:0]  avail_m [8];
	logic [7:0]  staged_m [8];
	logic [3:0]  procs_raw;
	logic [3:0]  res_raw;

	grant_result_t pending_results[$];
	int unsigned   mismatches;
	int unsigned   results_seen;
	int unsigned   items_sent;
	int unsigned   burst_left;
	bit            stall_mode;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int unsigned clamp_count(input logic [3:0] raw);
		if (raw == 4'd0)
			return 1;
		if (raw > 4'd8)
			return 8;
		return raw;
	endfunction

	function automatic bit find_safe_order(input int unsigned np, input int unsigned nr,
			output logic [2:0] order [8]);
		int unsigned work [8];
		bit done [8];
		bit found;
		bit fits;
		int unsigned s;
		for (int r = 0; r < 8; r++)
			work[r] = (r < nr) ? avail_m[r] : 0;
		for (int p = 0; p < 8; p++) begin
			done[p] = 1'b0;
			order[p] = 3'd0;
		end
		for (int c = 0; c < np; c++) begin
			found = 1'b0;
			for (int p = 0; p < np && !found; p++) begin
				if (!done[p]) begin
					fits = 1'b1;
					for (int r = 0; r < nr; r++)
						if (int'(max_m[p][r]) - int'(alloc_m[p][r]) > int'(work[r]))
							fits = 1'b0;
					if (fits) begin
						for (int r = 0; r < nr; r++) begin
							s = work[r] + alloc_m[p][r];
							work[r] = (s > 65535) ? 65535 : s;
						end
						done[p] = 1'b1;
						order[c] = p[2:0];
						found = 1'b1;
					end
				end
			end
			if (!found)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic push_single(input logic [2:0] st);
		grant_result_t item;
		item.st = st;
		item.seq = 3'd0;
		item.lst = 1'b1;
		pending_results.insert(pending_results.size(), item);
	endtask

	task automatic push_order(input logic [2:0] st, input int unsigned np,
			input logic [2:0] order [8]);
		grant_result_t item;
		for (int k = 0; k < np; k++) begin
			item.st = st;
			item.seq = order[k];
			item.lst = (k == np - 1);
			pending_results.insert(pending_results.size(), item);
		end
	endtask

	task automatic predict_banker(input logic [2:0] op, input logic [2:0] p,
			input logic [2:0] r, input logic [7:0] v);
		int unsigned np;
		int unsigned nr;
		logic [2:0] order [8];
		bit bad;
		np = clamp_count(procs_raw);
		nr = clamp_count(res_raw);
		case (op)
			OP_WRITE_ALLOC: begin
				alloc_m[p][r] = v;
				push_single(ST_ACK);
			end
			OP_WRITE_MAX: begin
				max_m[p][r] = v;
				push_single(ST_ACK);
			end
			OP_WRITE_AVAIL: begin
				avail_m[r] = v;
				push_single(ST_ACK);
			end
			OP_STAGE: begin
				staged_m[r] = v;
				push_single(ST_ACK);
			end
			OP_SUBMIT: begin
				bad = (p >= np);
				for (int k = 0; k < nr; k++)
					if (!bad && int'(staged_m[k]) > int'(max_m[p][k]) - int'(alloc_m[p][k]))
						bad = 1'b1;
				if (bad) begin
					push_single(ST_EXCEEDS_NEED);
				end else begin
					for (int k = 0; k < nr; k++)
						if (staged_m[k] > avail_m[k])
							bad = 1'b1;
					if (bad) begin
						push_single(ST_NOT_AVAIL);
					end else begin
						for (int k = 0; k < nr; k++) begin
							avail_m[k] = avail_m[k] - staged_m[k];
							alloc_m[p][k] = alloc_m[p][k] + staged_m[k];
						end
						if (find_safe_order(np, nr, order)) begin
							push_order(ST_GRANTED, np, order);
						end else begin
							for (int k = 0; k < nr; k++) begin
								avail_m[k] = avail_m[k] + staged_m[k];
								alloc_m[p][k] = alloc_m[p][k] - staged_m[k];
							end
							push_single(ST_DENIED);
						end
					end
				end
			end
			OP_CHECK: begin
				if (find_safe_order(np, nr, order))
					push_order(ST_SAFE, np, order);
				else
					push_single(ST_UNSAFE);
			end
			default: begin
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		$display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		grant_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", status, 0);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st)
					report_mismatch("status", status, e.st);
				if (sequence_process !== e.seq)
					report_mismatch("sequence_process", sequence_process, e.seq);
				if (last !== e.lst)
					report_mismatch("last", last, e.lst);
			end
			results_seen++;
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (($urandom & 63) == 0)
			stall_mode <= ~stall_mode;
		out_stall <= stall_mode ? (($urandom & 3) != 0) : 1'b0;
	end

	task automatic send_item(input logic [2:0] op, input logic [2:0] p,
			input logic [2:0] r, input logic [7:0] v);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		process_index <= p;
		resource_index <= r;
		value <= v;
		predict_banker(op, p, r, v);
		items_sent++;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [3:0] d);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_PROCESS_COUNT)
			procs_raw = d;
		else
			res_raw = d;
		@(posedge clk);
	endtask

	task automatic test_directed_extremes();
		send_item(OP_WRITE_ALLOC, 3'd7, 3'd7, 8'hff);
		send_item(OP_WRITE_MAX, 3'd7, 3'd7, 8'h00);
		send_item(OP_WRITE_MAX, 3'd0, 3'd0, 8'hff);
		send_item(OP_WRITE_AVAIL, 3'd7, 3'd0, 8'hff);
		send_item(OP_WRITE_AVAIL, 3'd0, 3'd0, 8'h05);
		send_item(OP_CHECK, 3'd0, 3'd0, 8'd0);
		send_item(3'd6, 3'd1, 3'd2, 8'h55);
		send_item(3'd7, 3'd5, 3'd6, 8'haa);
		send_item(OP_STAGE, 3'd0, 3'd0, 8'd9);
		send_item(OP_SUBMIT, 3'd0, 3'd0, 8'd0);
		send_item(OP_STAGE, 3'd0, 3'd0, 8'd3);
		send_item(OP_SUBMIT, 3'd0, 3'd0, 8'd0);
		send_item(OP_STAGE, 3'd0, 3'd0, 8'd200);
		send_item(OP_SUBMIT, 3'd0, 3'd0, 8'd0);
		send_item(OP_WRITE_AVAIL, 3'd0, 3'd0, 8'hff);
		send_item(OP_SUBMIT, 3'd0, 3'd0, 8'd0);
		send_item(OP_CHECK, 3'd0, 3'd0, 8'd0);
	endtask

	task automatic test_small_counts();
		write_register(CFG_PROCESS_COUNT, 4'd0);
		write_register(CFG_RESOURCE_COUNT, 4'd0);
		send_item(OP_SUBMIT, 3'd3, 3'd0, 8'd0);
		send_item(OP_STAGE, 3'd0, 3'd0, 8'd0);
		send_item(OP_SUBMIT, 3'd0, 3'd0, 8'd0);
		send_item(OP_CHECK, 3'd0, 3'd0, 8'd0);
		write_register(CFG_PROCESS_COUNT, 4'd15);
		write_register(CFG_RESOURCE_COUNT, 4'd15);
		send_item(OP_CHECK, 3'd0, 3'd0, 8'd0);
	endtask

	task automatic random_scenario(input int unsigned n_items);
		logic [2:0] op;
		int unsigned sel;
		for (int i = 0; i < n_items; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 22)      op = OP_WRITE_ALLOC;
			else if (sel < 44) op = OP_WRITE_MAX;
			else if (sel < 56) op = OP_WRITE_AVAIL;
			else if (sel < 72) op = OP_STAGE;
			else if (sel < 86) op = OP_SUBMIT;
			else if (sel < 97) op = OP_CHECK;
			else               op = 3'($urandom_range(6, 7));
			// mostly small counts so requests are often grantable
			send_item(op, 3'($urandom), 3'($urandom),
				($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
		end
	endtask

	task automatic test_random_phases();
		random_scenario(70);
		write_register(CFG_PROCESS_COUNT, 4'd3);
		write_register(CFG_RESOURCE_COUNT, 4'd2);
		random_scenario(70);
		write_register(CFG_PROCESS_COUNT, 4'd1);
		write_register(CFG_RESOURCE_COUNT, 4'd8);
		random_scenario(50);
		write_register(CFG_PROCESS_COUNT, 4'd8);
		write_register(CFG_RESOURCE_COUNT, 4'd1);
		random_scenario(60);
		write_register(CFG_PROCESS_COUNT, 4'd5);
		write_register(CFG_RESOURCE_COUNT, 4'd4);
		random_scenario(40);
	endtask

	initial begin
		for (int p = 0; p < 8; p++) begin
			avail_m[p] = '0;
			staged_m[p] = '0;
			for (int r = 0; r < 8; r++) begin
				alloc_m[p][r] = '0;
				max_m[p][r] = '0;
			end
		end
		procs_raw = 4'd8;
		res_raw = 4'd8;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		burst_left = 0;
		stall_mode = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = '0;
		process_index = '0;
		resource_index = '0;
		value = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_small_counts();
		test_random_phases();
		drain_results();

		$display("ran %0d items and checked %0d results across six register settings",
			items_sent, results_seen);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
